@@ sv/lcs_pkg.sv @@
// Shared constants, types and the sRGB linearization table for the Lab color comparator.
package lcs_pkg;

    // Default number of Lab fraction bits
    localparam int LAB_FRAC_BITS_DEF = 8;

    // Field and datapath widths
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int LIN_W      = 17;   // linear channel, Q16, up to 1.0
    localparam int COEF_W     = 20;
    localparam int XYZ_NUM_W  = 37;   // matrix numerator
    localparam int XYZ_W      = 17;   // normalized XYZ, Q16
    localparam int XYZ_FRAC   = 16;
    localparam int F_W        = 17;   // f() result, Q16
    localparam int LAB_RAW_W  = 28;   // Lab before rounding, Q16 signed
    localparam int TOL_W      = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd100;

    // Pipeline depths
    localparam int DIV_LAT    = 3;
    localparam int CBRT_STEPS = 18;
    localparam int F_LAT      = CBRT_STEPS + 1;
    localparam int LANE_LAT   = 3 + DIV_LAT + F_LAT + 2;
    localparam int MERGE_LAT  = 4;

    // Cube root working widths
    localparam int CBRT_R_W   = 19;
    localparam int CBRT_SQ_W  = 38;
    localparam int CBRT_CU_W  = 56;
    localparam int CBRT_TGT_W = XYZ_W + 32;

    // RGB to XYZ matrix scaled by 1000000; the white point is divided out later by XYZ_DIV
    typedef logic [COEF_W-1:0] coef_mat_t [3][3];
    localparam coef_mat_t XYZ_COEF = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };
    localparam longint unsigned XYZ_ROUND [3] = '{475235, 500000, 544415};
    localparam longint unsigned XYZ_DIV   [3] = '{950470, 1000000, 1088830};

    // Linear segment of f()
    localparam int FLIN_NUM_W = 37;
    localparam longint unsigned FLIN_MUL = 903292;      // 7.787 * 116 scaled
    localparam longint unsigned FLIN_ADD = 1048634000;  // 16/116 offset plus rounding
    localparam longint unsigned FLIN_DIV = 116000;
    localparam int F_KNEE = (8856 * 65536) / 1000000;  // cube root above this

    // Lab scaling
    localparam int L_MUL = 116;
    localparam int L_OFS = 16 * 65536;
    localparam int A_MUL = 500;
    localparam int B_MUL = 200;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // Floor fifth root of a Q30 value
    function automatic logic [63:0] fifth_root_q30(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        int bit_i;
        r = '0;
        for (bit_i = 30; bit_i >= 0; bit_i--) begin
            c  = r | (64'd1 << bit_i);
            p2 = (c * c) >> 30;
            p4 = (p2 * p2) >> 30;
            p5 = (p4 * c) >> 30;
            if (p5 <= s) begin
                r = c;
            end
        end
        return r;
    endfunction

    // sRGB gamma expansion, Q16
    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        logic [63:0] code;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] v;
        int c;
        for (c = 0; c < 256; c++) begin
            code = 64'(c);
            if (c <= 10) begin
                tbl[c] = LIN_W'((code * 64'd6553600 + 64'd164730) / 64'd329460);
            end else begin
                t = ((64'd1000 * code + 64'd14025) << 30) / 64'd269025;
                s = (t * t) >> 30;
                r = fifth_root_q30(s);
                v = (s * r) >> 30;
                tbl[c] = LIN_W'((v + 64'd8192) >> 14);
            end
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

@@ sv/lcs_cdiv.sv @@
// Pipelined division by a constant: reciprocal multiply, then one correction step.
module lcs_cdiv #(
    parameter int NUM_W = 37,
    parameter longint unsigned DIVISOR = 1000,
    parameter int Q_W = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    output logic [Q_W-1:0]   quo
);

    localparam logic [63:0] RECIP = (64'd1 << NUM_W) / DIVISOR;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int D_W     = $clog2(DIVISOR + 1);
    localparam int REM_W   = D_W + 1;
    localparam logic [REM_W-1:0] DIV_LO = REM_W'(DIVISOR);

    logic [PROD_W-1:0] prod_reg;
    logic [REM_W-1:0]  n1_reg;
    logic [Q_W-1:0]    q0;
    logic [Q_W-1:0]    q0_reg;
    logic [REM_W-1:0]  qd_reg;
    logic [REM_W-1:0]  n2_reg;
    logic [REM_W-1:0]  rem;
    logic [Q_W-1:0]    quo_reg;

    // estimate is the true quotient or one below it
    assign q0  = Q_W'(prod_reg >> NUM_W);
    // remainder stays below twice the divisor, so low bits suffice
    assign rem = n2_reg - qd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(num) * PROD_W'(RECIP);
            n1_reg   <= num[REM_W-1:0];
            q0_reg   <= q0;
            qd_reg   <= REM_W'(q0) * DIV_LO;
            n2_reg   <= n1_reg;
            quo_reg  <= q0_reg + Q_W'(rem >= DIV_LO);
        end
    end

    assign quo = quo_reg;

endmodule

@@ sv/lcs_lab_f.sv @@
// Lab f(): 18-stage bit-per-stage cube root beside the linear segment, selected at the end.
module lcs_lab_f
    import lcs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [XYZ_W-1:0] v,
    output logic [F_W-1:0]   f
);

    localparam int LIN_DLY = CBRT_STEPS - 1 - DIV_LAT;

    typedef struct packed {
        logic [CBRT_R_W-1:0]   r;
        logic [CBRT_SQ_W-1:0]  sq;
        logic [CBRT_CU_W-1:0]  cu;
        logic [CBRT_TGT_W-1:0] tgt;
    } cbrt_t;

    cbrt_t                 cbrt_reg [CBRT_STEPS];
    logic [FLIN_NUM_W-1:0] lin_num_reg;
    logic [F_W-1:0]        lin_q;
    logic [F_W-1:0]        lin_dly_reg [LIN_DLY];
    logic                  knee_reg [CBRT_STEPS];
    logic [F_W-1:0]        f_reg;

    // cube root, one result bit per stage, tracking r, r^2 and r^3
    for (genvar j = 0; j < CBRT_STEPS; j++)
    begin : g_step
        localparam int B = CBRT_STEPS - 1 - j;
        cbrt_t prev;
        cbrt_t nxt;
        logic [CBRT_CU_W-1:0] cand_cu;
        logic [CBRT_SQ_W-1:0] cand_sq;

        if (j == 0)
        begin : g_first
            assign prev.r   = '0;
            assign prev.sq  = '0;
            assign prev.cu  = '0;
            assign prev.tgt = {v, 32'd0};
        end
        else
        begin : g_rest
            assign prev = cbrt_reg[j-1];
        end

        always_comb
        begin
            cand_cu = prev.cu + ((CBRT_CU_W'(prev.sq) * 3) << B)
                    + ((CBRT_CU_W'(prev.r) * 3) << (2 * B)) + (CBRT_CU_W'(1) << (3 * B));
            cand_sq = prev.sq + (CBRT_SQ_W'(prev.r) << (B + 1)) + (CBRT_SQ_W'(1) << (2 * B));
            nxt = prev;
            if (cand_cu <= CBRT_CU_W'(prev.tgt))
            begin
                nxt.r  = prev.r | (CBRT_R_W'(1) << B);
                nxt.sq = cand_sq;
                nxt.cu = cand_cu;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cbrt_reg[j] <= nxt;
            end
        end
    end

    // linear segment numerator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_num_reg <= FLIN_NUM_W'(v) * FLIN_NUM_W'(FLIN_MUL) + FLIN_NUM_W'(FLIN_ADD);
        end
    end

    lcs_cdiv #(
        .NUM_W   (FLIN_NUM_W),
        .DIVISOR (FLIN_DIV),
        .Q_W     (F_W)
    ) u_lin_div (
        .clk (clk),
        .en  (en),
        .num (lin_num_reg),
        .quo (lin_q)
    );

    // align segment choice and linear value with the cube root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            knee_reg[0]    <= v > XYZ_W'(F_KNEE);
            lin_dly_reg[0] <= lin_q;
            for (int i = 1; i < CBRT_STEPS; i++)
            begin
                knee_reg[i] <= knee_reg[i-1];
            end
            for (int i = 1; i < LIN_DLY; i++)
            begin
                lin_dly_reg[i] <= lin_dly_reg[i-1];
            end
            f_reg <= knee_reg[CBRT_STEPS-1] ? F_W'(cbrt_reg[CBRT_STEPS-1].r)
                                             : lin_dly_reg[LIN_DLY-1];
        end
    end

    assign f = f_reg;

endmodule

@@ sv/lcs_lab_lane.sv @@
// One color lane: sRGB lookup, XYZ matrix and normalization, f(), Lab scaling and rounding.
module lcs_lab_lane
    import lcs_pkg::*;
#(
    parameter int LAB_FRAC_BITS = LAB_FRAC_BITS_DEF,
    localparam int SH    = XYZ_FRAC - LAB_FRAC_BITS,
    localparam int LAB_W = LAB_RAW_W - SH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [COLOR_W-1:0]      color,
    output logic                    out_valid,
    output logic signed [LAB_W-1:0] lab [3]
);

    localparam logic signed [LAB_RAW_W-1:0] LMUL = LAB_RAW_W'(L_MUL);
    localparam logic signed [LAB_RAW_W-1:0] LOFS = LAB_RAW_W'(L_OFS);
    localparam logic signed [LAB_RAW_W-1:0] AMUL = LAB_RAW_W'(A_MUL);
    localparam logic signed [LAB_RAW_W-1:0] BMUL = LAB_RAW_W'(B_MUL);

    logic [LIN_W-1:0]            lin_reg  [3];
    logic [XYZ_NUM_W-1:0]        prod_reg [3][3];
    logic [XYZ_NUM_W-1:0]        num_reg  [3];
    logic [XYZ_W-1:0]            xyz      [3];
    logic [F_W-1:0]              fv       [3];
    logic signed [LAB_RAW_W-1:0] fs       [3];
    logic signed [LAB_RAW_W-1:0] raw_reg  [3];
    logic signed [LAB_W-1:0]     lab_reg  [3];
    logic                        valid_reg [LANE_LAT];

    // gamma lookup, matrix products, row sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lin_reg[c] <= LIN_TABLE[color[CHAN_W*c +: CHAN_W]];
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= XYZ_NUM_W'(XYZ_COEF[r][c]) * XYZ_NUM_W'(lin_reg[c]);
                end
                num_reg[r] <= prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2]
                            + XYZ_NUM_W'(XYZ_ROUND[r]);
            end
        end
    end

    // white-point normalization and f() per component
    for (genvar r = 0; r < 3; r++)
    begin : g_comp
        lcs_cdiv #(
            .NUM_W   (XYZ_NUM_W),
            .DIVISOR (XYZ_DIV[r]),
            .Q_W     (XYZ_W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[r]),
            .quo (xyz[r])
        );

        lcs_lab_f u_f (
            .clk (clk),
            .en  (en),
            .v   (xyz[r]),
            .f   (fv[r])
        );

        assign fs[r] = LAB_RAW_W'(fv[r]);
    end

    // L, a, b in Q16
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg[0] <= fs[1] * LMUL - LOFS;
            raw_reg[1] <= (fs[0] - fs[1]) * AMUL;
            raw_reg[2] <= (fs[1] - fs[2]) * BMUL;
        end
    end

    // round half up to the Lab fraction width
    for (genvar r = 0; r < 3; r++)
    begin : g_round
        if (SH == 0)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lab_reg[r] <= LAB_W'(raw_reg[r]);
                end
            end
        end
        else
        begin : g_shift
            localparam logic signed [LAB_RAW_W-1:0] HALF = LAB_RAW_W'(1) << (SH - 1);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lab_reg[r] <= LAB_W'((raw_reg[r] + HALF) >>> SH);
                end
            end
        end
        assign lab[r] = lab_reg[r];
    end

    // item valid travels beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[LANE_LAT-1];

endmodule

@@ sv/lcs_merge.sv @@
// Merge stage: squared Lab distance of the two lanes and the tolerance compare.
module lcs_merge
    import lcs_pkg::*;
#(
    parameter int LAB_FRAC_BITS = LAB_FRAC_BITS_DEF,
    localparam int LAB_W = LAB_RAW_W - (XYZ_FRAC - LAB_FRAC_BITS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [LAB_W-1:0] lab_p [3],
    input  logic signed [LAB_W-1:0] lab_q [3],
    input  logic [TOL_W-1:0]        tolerance,
    output logic                    out_valid,
    output logic                    similar
);

    localparam int DIFF_W = LAB_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;

    logic signed [DIFF_W-1:0]   diff_reg [3];
    logic signed [SQ_W-1:0]     sq_reg   [3];
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           thresh;
    logic                       similar_reg;
    logic                       valid_reg [MERGE_LAT];

    assign thresh = SUM_W'(tolerance) << (2 * LAB_FRAC_BITS);

    // difference, square, sum, compare
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= DIFF_W'(lab_p[i]) - DIFF_W'(lab_q[i]);
                sq_reg[i]   <= SQ_W'(diff_reg[i]) * SQ_W'(diff_reg[i]);
            end
            sum_reg     <= SUM_W'(unsigned'(sq_reg[0])) + SUM_W'(unsigned'(sq_reg[1]))
                         + SUM_W'(unsigned'(sq_reg[2]));
            similar_reg <= sum_reg < thresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MERGE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < MERGE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[MERGE_LAT-1];
    assign similar   = similar_reg;

endmodule

@@ sv/lab_color_similarity.sv @@
// Top level: two Lab conversion lanes, distance merge and the tolerance register.
//
// Compares two sRGB colors by squared CIE76 Lab distance against the tolerance
// register and returns one similar flag per item. The block is fully pipelined:
// it takes one item every clock while no result is stalled at the output; its
// two colors pass through the two conversion lanes, dominated by the 18-stage cube
// root of f(), and then through the distance merge. The whole pipeline advances
// together; s_axis_tready is high whenever the output register is empty or
// being read, so a stalled result stalls the input. Write tolerance only while
// no item is in flight.
module lab_color_similarity
    import lcs_pkg::*;
#(
    parameter int LAB_FRAC_BITS = LAB_FRAC_BITS_DEF,
    localparam int LAB_W = LAB_RAW_W - (XYZ_FRAC - LAB_FRAC_BITS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,  // color_first [23:0], color_second [47:24]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,  // similar [0], zero [7:1]
    input  logic               cfg_wr_en,
    input  logic [TOL_W-1:0]   cfg_wr_data
);

    logic                    en;
    logic                    valid_p;
    logic                    valid_q;
    logic signed [LAB_W-1:0] lab_p [3];
    logic signed [LAB_W-1:0] lab_q [3];
    logic [TOL_W-1:0]        tolerance_reg;
    logic                    similar;

    // pipeline advances unless a result waits at the output
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tolerance_reg <= cfg_wr_data;
        end
    end

    lcs_lab_lane #(
        .LAB_FRAC_BITS (LAB_FRAC_BITS)
    ) u_lane_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .color     (s_axis_tdata[23:0]),
        .out_valid (valid_p),
        .lab       (lab_p)
    );

    lcs_lab_lane #(
        .LAB_FRAC_BITS (LAB_FRAC_BITS)
    ) u_lane_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .color     (s_axis_tdata[47:24]),
        .out_valid (valid_q),
        .lab       (lab_q)
    );

    lcs_merge #(
        .LAB_FRAC_BITS (LAB_FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_p && valid_q),
        .lab_p     (lab_p),
        .lab_q     (lab_q),
        .tolerance (tolerance_reg),
        .out_valid (m_axis_tvalid),
        .similar   (similar)
    );

    assign m_axis_tdata = {7'd0, similar};

endmodule

@@ sv/lcs_checker.sv @@
// Port-level assertions for the Lab comparator, bound to the top level.
module lcs_checker
    import lcs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [47:0]      s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [7:0]       m_axis_tdata,
    input logic             cfg_wr_en,
    input logic [TOL_W-1:0] cfg_wr_data
);

    logic [TOL_W-1:0] tol_shadow_reg;

    // shadow of the tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_shadow_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_shadow_reg <= cfg_wr_data;
        end
    end

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input side is ready exactly when the output can move
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");

    // zero tolerance never reports a match
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (tol_shadow_reg == '0) |-> !m_axis_tdata[0])
        else $error("match reported with zero tolerance");

    // pad bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result pad bits not zero");

endmodule

bind lab_color_similarity lcs_checker u_lcs_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the Lab color comparator: stream driver, monitor, checker.
module testbench
    import lcs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;    // color_first [23:0], color_second [47:24]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;    // similar [0], zero [7:1]
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;

    lab_color_similarity #(.LAB_FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Color pairs waiting to be sent, similar flags waiting to arrive
    logic [47:0]  color_pairs[$];
    logic         similar_due[$];
    logic [16:0]  srgb_lin[256];
    logic [15:0]  tol_now;
    int           send_idle;
    int           recv_idle;
    bit           hold_send;
    bit           took;
    int           errors;
    int           results_seen;
    int           similar_seen;
    int           cycles;

    // Floor fifth root in Q30
    function automatic longint unsigned root5_q30(longint unsigned s);
        longint unsigned r, c, p2, p4, p5;
        r = 0;
        for (int k = 30; k >= 0; k--)
        begin
            c = r | (64'd1 << k);
            p2 = (c * c) >> 30;
            p4 = (p2 * p2) >> 30;
            p5 = (p4 * c) >> 30;
            if (p5 <= s)
                r = c;
        end
        return r;
    endfunction

    // Lab companding function f(), Q16 in and out
    function automatic longint f_lab(longint unsigned v);
        longint unsigned goal, r, c;
        if (v * 64'd1000000 > 64'd8856 * 64'd65536)
        begin
            goal = v << 32;
            r = 0;
            for (int k = 17; k >= 0; k--)
            begin
                c = r | (64'd1 << k);
                if (c * c * c <= goal)
                    r = c;
            end
            return longint'(r);
        end
        return longint'((v * 64'd7787 * 64'd116 + 64'd16000 * 64'd65536 + 64'd58000)
                        / 64'd116000);
    endfunction

    // Round Q16 to FRAC fraction bits, ties toward +inf
    function automatic longint q16_round(longint v);
        return (v + (64'sd1 <<< (15 - FRAC))) >>> (16 - FRAC);
    endfunction

    // sRGB color to Lab triple
    function automatic void color_lab(logic [23:0] col, output longint lab[3]);
        longint unsigned r, g, b, x, y, z;
        longint fx, fy, fz;
        r = srgb_lin[col[7:0]];
        g = srgb_lin[col[15:8]];
        b = srgb_lin[col[23:16]];
        x = (412453 * r + 357580 * g + 180423 * b + 475235) / 950470;
        y = (212671 * r + 715160 * g + 72169 * b + 500000) / 1000000;
        z = (19334 * r + 119193 * g + 950227 * b + 544415) / 1088830;
        fx = f_lab(x);
        fy = f_lab(y);
        fz = f_lab(z);
        lab[0] = q16_round(116 * fy - 16 * 65536);
        lab[1] = q16_round(500 * (fx - fy));
        lab[2] = q16_round(200 * (fy - fz));
    endfunction

    // Squared Lab distance against tolerance
    function automatic logic colors_similar(logic [47:0] pair, logic [15:0] tol);
        longint p[3], q[3], d;
        longint unsigned dist_sum;
        color_lab(pair[23:0], p);
        color_lab(pair[47:24], q);
        dist_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = p[i] - q[i];
            dist_sum += longint'(d * d);
        end
        return dist_sum < (longint'(tol) << (2 * FRAC));
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("%0t timeout with %0d results pending", $time, similar_due.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Driver: items and result backpressure change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !took)
                s_axis_tvalid <= 1'b1;
            else if (!hold_send && color_pairs.size() > 0
                     && $urandom_range(99) >= send_idle)
            begin
                s_axis_tdata  <= color_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        took <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            similar_due.push_back(colors_similar(s_axis_tdata, tol_now));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (similar_due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %0d",
                         $time, m_axis_tdata[0]);
            end
            else
            begin
                if (m_axis_tdata[0] !== similar_due[0])
                begin
                    errors++;
                    $display("%0t similar mismatch: expected %0d, actual %0d",
                             $time, similar_due[0], m_axis_tdata[0]);
                end
                similar_seen += similar_due[0];
                void'(similar_due.pop_front());
            end
        end
    end

    // Wait until all items are taken and every result has come back
    task automatic drain();
        while (color_pairs.size() > 0 || s_axis_tvalid || similar_due.size() > 0)
            @(posedge clk);
    endtask

    // Tolerance write while the pipeline is empty
    task automatic write_tol(logic [15:0] value);
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tol_now = value;
    endtask

    // Random pairs: mostly near colors so both outcomes occur
    task automatic queue_random(int count);
        logic [23:0] a, b;
        int spread;
        for (int n = 0; n < count; n++)
        begin
            a = 24'($urandom);
            if ($urandom_range(3) == 0)
                b = 24'($urandom);
            else
            begin
                spread = 1 << $urandom_range(6);
                for (int ch = 0; ch < 3; ch++)
                    b[ch*8 +: 8] = 8'(int'(a[ch*8 +: 8]) + $urandom_range(2 * spread)
                                      - spread);
            end
            color_pairs.push_back({b, a});
        end
    endtask

    // Stimulus sequence
    initial
    begin
        logic [15:0] tol_set[6] = '{16'd0, 16'd65535, 16'd1, 16'd2500, 16'd300, 16'd20};
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        hold_send = 0;
        took = 0;
        errors = 0;
        results_seen = 0;
        similar_seen = 0;
        cycles = 0;
        tol_now = TOL_RESET;
        send_idle = 31;
        recv_idle = 53;

        // Gamma expansion: linear segment, then power segment via fifth root
        for (int c = 0; c < 256; c++)
        begin
            longint unsigned t, s, r;
            if (c <= 10)
                srgb_lin[c] = 17'((longint'(c) * 6553600 + 164730) / 329460);
            else
            begin
                t = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
                s = (t * t) >> 30;
                r = root5_q30(s);
                srgb_lin[c] = 17'((((s * r) >> 30) + 64'd8192) >> 14);
            end
        end

        repeat (11) @(negedge clk);
        rst_n = 1;

        // Directed: extremes, gamma knee, f() knee, identical colors
        color_pairs.push_back({24'h000000, 24'h000000});
        color_pairs.push_back({24'hFFFFFF, 24'hFFFFFF});
        color_pairs.push_back({24'hFFFFFF, 24'h000000});
        color_pairs.push_back({24'h000000, 24'hFFFFFF});
        color_pairs.push_back({24'h0A0A0A, 24'h0B0B0B});
        color_pairs.push_back({24'h0A0A0A, 24'h0A0A0A});
        color_pairs.push_back({24'h000001, 24'h000000});
        color_pairs.push_back({24'h080808, 24'h090909});
        color_pairs.push_back({24'h0000FF, 24'h00FF00});
        color_pairs.push_back({24'hFF0000, 24'h0000FF});
        color_pairs.push_back({24'h808080, 24'h838383});
        color_pairs.push_back({24'h7F7F7F, 24'h808080});
        color_pairs.push_back({24'hFFFFFE, 24'hFFFFFF});
        color_pairs.push_back({24'h123456, 24'h123457});
        color_pairs.push_back({24'hAA5500, 24'h55AAFF});
        color_pairs.push_back({24'h010203, 24'h030201});
        queue_random(200);

        // Sender held off mid-stream until every pending result is back
        repeat (100) @(posedge clk);
        hold_send = 1;
        while (s_axis_tvalid || similar_due.size() > 0) @(posedge clk);
        hold_send = 0;
        drain();
        color_pairs.push_back({24'h202020, 24'h212121});

        // Tolerance sweep across idle patterns
        for (int p = 0; p < 6; p++)
        begin
            write_tol(tol_set[p]);
            if (p == 2)
            begin
                send_idle = 53;
                recv_idle = 31;
            end
            if (p == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            color_pairs.push_back({24'hFFFFFF, 24'h000000});
            color_pairs.push_back({24'h000000, 24'h000000});
            queue_random(190);
        end
        write_tol(TOL_RESET);
        queue_random(40);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d similarity results (%0d similar) over 7 tolerance settings",
                 results_seen, similar_seen);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
